// ===== rtl/core/bucketed_hash_map_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bucketed hash map
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef BUCKETED_HASH_MAP_ASSERT_SVH
`define BUCKETED_HASH_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bhm_pkg.sv =====
// ---------------------------------------------------------------------------
// bhm_pkg
// Shared types and constants of the bucketed hash map.
// ---------------------------------------------------------------------------
package bhm_pkg;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int ACT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2
  } bhm_act_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } bhm_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_UPDATE
  } bhm_state_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } bhm_slot_t;

  localparam int SLOT_W = $bits(bhm_slot_t);

endpackage

// ===== rtl/core/bucketed_hash_map.sv =====
// ---------------------------------------------------------------------------
// bucketed_hash_map
// Hash map with key-modulo buckets of WAYS entries each, one bucket per RAM row.
//
//   Channel | Ports        | Carries
//   --------+--------------+---------------------------------------------
//   in      | in_t*        | request: action, key, value
//   out     | out_t*       | result: status, found value
//
// A request passes through accept, row read, compare and write back
// before the next acceptance; when BUCKETS is not a power of two, the row
// read also waits while the bucket index unit walks the key.
// After reset a clearing pass writes every bucket row with in_tready
// low. The result sits in an output register, so a stalled out_tready
// holds only the write-back stage; the next request is taken as soon as
// that result has been handed over to the register.
// ---------------------------------------------------------------------------
`include "bucketed_hash_map_assert.svh"

module bucketed_hash_map import bhm_pkg::*; #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [30:0] key, [62:31] value, [63] zero
  input  logic [ACT_W-1:0]      in_tuser,   // [1:0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] found_value
  output logic [STATUS_W-1:0]   out_tuser   // [1:0] status
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int WIX   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WP    = 1 << WIX;
  localparam int ROW_W = WAYS * SLOT_W;

  bhm_state_t state_r, state_nxt;
  logic [BW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [ACT_W-1:0] req_act_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;

  logic          in_acc;
  logic          hash_ready;
  logic [BW-1:0] bucket;

  logic             ram_we, ram_re;
  logic [BW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  bhm_slot_t [WAYS-1:0] row_rd, row_upd;
  logic [WAYS-1:0] hit_r, hit_nxt;
  logic            dup_r, dup_nxt;

  logic             node_ok  [2*WP];
  logic [VAL_W-1:0] node_v   [2*WP];
  logic [WIX-1:0]   node_idx [2*WP];

  logic             free_ok;
  logic [WIX-1:0]   free_idx;
  bhm_status_t      upd_status;
  logic [VAL_W-1:0] upd_value;
  logic             upd_write;
  logic             out_free, out_load;

  logic             out_tvalid_r;
  bhm_status_t      out_status_r;
  logic [VAL_W-1:0] out_value_r;

  bhm_bucket_idx #(
    .BUCKETS(BUCKETS)
  ) u_bucket_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .key   (in_tdata[KEY_W-1:0]),
    .ready (hash_ready),
    .bucket(bucket)
  );

  bhm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(bucket),
    .rdata(ram_rdata)
  );

  assign in_acc   = in_tvalid & in_tready;
  assign out_free = ~out_tvalid_r | out_tready;
  assign row_rd   = ram_rdata;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_ready) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ram_waddr = bucket;
    ram_wdata = row_upd;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_HASH: begin
        ram_re = hash_ready;
      end
      S_UPDATE: begin
        out_load = out_free;
        ram_we   = out_free & upd_write;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Per-way compare against the row just read.
  always_comb begin
    dup_nxt = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_nxt[w] = row_rd[w].used && (row_rd[w].key == req_key_r);
      if (hit_nxt[w] && (row_rd[w].value == req_val_r)) begin
        dup_nxt = 1'b1;
      end
    end
  end

  // Smallest-value match: a tree over the ways, the lower way winning ties.
  for (genvar g = 0; g < WP; g++) begin : g_leaf
    if (g < WAYS) begin : g_real
      assign node_ok[WP+g]  = hit_r[g];
      assign node_v[WP+g]   = row_rd[g].value;
    end else begin : g_pad
      assign node_ok[WP+g]  = 1'b0;
      assign node_v[WP+g]   = '0;
    end
    assign node_idx[WP+g] = WIX'(g);
  end

  for (genvar n = 1; n < WP; n++) begin : g_node
    logic take_left;
    assign take_left   = node_ok[2*n] &&
                         (!node_ok[2*n+1] || (node_v[2*n] <= node_v[2*n+1]));
    assign node_ok[n]  = node_ok[2*n] | node_ok[2*n+1];
    assign node_v[n]   = take_left ? node_v[2*n]   : node_v[2*n+1];
    assign node_idx[n] = take_left ? node_idx[2*n] : node_idx[2*n+1];
  end

  assign node_ok[0]  = 1'b0;
  assign node_v[0]   = '0;
  assign node_idx[0] = '0;

  // Lowest free way.
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!row_rd[w].used) begin
        free_ok  = 1'b1;
        free_idx = WIX'(w);
      end
    end
  end

  // Result and new row contents.
  always_comb begin
    row_upd    = row_rd;
    upd_status = STS_MISS;
    upd_value  = '0;
    upd_write  = 1'b0;
    case (req_act_r)
      ACT_INSERT: begin
        if (dup_r) begin
          upd_status = STS_DONE;
        end else if (!free_ok) begin
          upd_status = STS_FULL;
        end else begin
          upd_status = STS_DONE;
          upd_write  = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (free_idx == WIX'(w)) begin
              row_upd[w].used  = 1'b1;
              row_upd[w].key   = req_key_r;
              row_upd[w].value = req_val_r;
            end
          end
        end
      end
      ACT_REMOVE: begin
        if (node_ok[1]) begin
          upd_status = STS_DONE;
          upd_write  = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (node_idx[1] == WIX'(w)) begin
              row_upd[w].used = 1'b0;
            end
          end
        end
      end
      ACT_FIND: begin
        if (node_ok[1]) begin
          upd_status = STS_DONE;
          upd_value  = node_v[1];
        end
      end
      default: begin
        upd_status = STS_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_act_r <= in_tuser;
      req_key_r <= in_tdata[KEY_W-1:0];
      req_val_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (state_r == S_READ) begin
      hit_r <= hit_nxt;
      dup_r <= dup_nxt;
    end
    if (out_load) begin
      out_status_r <= upd_status;
      out_value_r  <= upd_value;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  `BHM_ASSERT_NEXT(a_accept_to_hash, in_tvalid && in_tready, state_r == S_HASH, "accepted request did not start a lookup")
  `BHM_ASSERT_SAME(a_write_phase, ram_we, (state_r == S_CLEAR) || (state_r == S_UPDATE && out_free), "bucket row written outside clear or update")
  `BHM_ASSERT_SAME(a_no_rw_overlap, ram_re, !ram_we, "bucket row read and written in the same cycle")
  `BHM_ASSERT_SAME(a_result_source, $rose(out_tvalid_r), $past(state_r) == S_UPDATE, "result appeared without an update")
  `BHM_ASSERT_SAME(a_miss_zero, out_tvalid_r && (out_status_r != STS_DONE), out_value_r == '0, "found value nonzero on a failed request")

endmodule

// ===== rtl/core/bhm_ram.sv =====
// ---------------------------------------------------------------------------
// bhm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bhm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bhm_bucket_idx.sv =====
// ---------------------------------------------------------------------------
// bhm_bucket_idx
// Bucket index unit: key modulo BUCKETS, a bit mask for powers of two and
// otherwise a remainder walk over eight key bits per cycle.
// ---------------------------------------------------------------------------
module bhm_bucket_idx import bhm_pkg::*; #(
  parameter int BUCKETS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [KEY_W-1:0]           key,
  output logic                       ready,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(BUCKETS);

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
    logic done_r;
    logic [BW-1:0] bucket_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else if (load) begin
        done_r <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        bucket_r <= key[BW-1:0];
      end
    end

    assign ready  = done_r;
    assign bucket = bucket_r;
  end else begin : g_walk
    localparam int DIG_W = 8;
    localparam int PAD_W = ((KEY_W + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int STEPS = PAD_W / DIG_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int RW    = BW + 1;

    logic [PAD_W-1:0] sh_r, sh_nxt;
    logic [CNT_W-1:0] cnt_r, cnt_nxt;
    logic [BW-1:0]    rem_r, rem_nxt;
    logic [BW-1:0]    r_step;
    logic [RW-1:0]    t_step;

    // Each step doubles the running remainder, brings in the next key bit
    // and subtracts the modulus once when it overflows.
    always_comb begin
      r_step = rem_r;
      t_step = '0;
      for (int i = 0; i < DIG_W; i++) begin
        t_step = {r_step, sh_r[PAD_W-1-i]};
        if (t_step >= RW'(BUCKETS)) begin
          t_step = t_step - RW'(BUCKETS);
        end
        r_step = t_step[BW-1:0];
      end
    end

    always_comb begin
      sh_nxt  = sh_r;
      cnt_nxt = cnt_r;
      rem_nxt = rem_r;
      if (load) begin
        sh_nxt  = PAD_W'(key);
        cnt_nxt = CNT_W'(STEPS);
        rem_nxt = '0;
      end else if (cnt_r != '0) begin
        sh_nxt  = sh_r << DIG_W;
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = r_step;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end

    always_ff @(posedge clk) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end

    assign ready  = (cnt_r == '0);
    assign bucket = rem_r;
  end

endmodule
